[hdl/tph_pkg.sv]
// Package for the triage priority heap: sizes, entry layout, status codes,
// sequencer states and the entry ordering function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tph_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 3;
  localparam int SEQ_W    = 32;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FULL_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_OUT
  } state_e;

  // a ranks above b: higher priority, or equal priority and earlier sequence
  function automatic logic beats(entry_t a, entry_t b);
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    return a.seq < b.seq;
  endfunction

endpackage

`default_nettype wire

[hdl/triage_priority_heap_unit.sv]
// Top level of the triage priority heap: entry memory, sift sequencer and
// stream ports. Depends on tph_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Binary max-heap priority queue of up to 128 entries held in one on-chip
// memory (one write port, two registered read ports). Each beat on the slave
// side is one command: tuser 0 inserts (id, priority), tuser 1 removes the
// top entry; exactly one result beat follows for every command. Higher
// priority leaves first, and equal priorities leave in arrival order. On a
// full heap an insert evicts the entry in the last slot if its priority is
// lower, otherwise it is rejected. One command is in flight at a time;
// tready stays low from its accepting edge until its result is registered.
// An insert compares with the parent per level it climbs, after a check of
// the last slot on a full heap; a remove loads the top and last entries, then
// compares both children per level the moved entry descends. The longest
// command is an evicting insert from the last slot that climbs to the root;
// each level is a read-compare-write step of the sift loop on the entry
// memory. A pending result beat does not block the next command; it only
// holds the finishing cycle of that command.
module triage_priority_heap_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,  // [15:0] patient_id, [18:16] priority_req, [23:19] zero
  input  wire         s_axis_tuser,  // [0] func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] out_id, [18:16] out_priority, [23:19] zero
  output logic [2:0]  m_axis_tuser   // [2:0] status
);

  localparam int AW = tph_pkg::ADDR_W;
  localparam int CW = tph_pkg::CNT_W;
  localparam int IW = tph_pkg::IDX_W;

  tph_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [tph_pkg::SEQ_W-1:0] seq_q, seq_d;
  logic [AW-1:0]    pos_q, pos_d;
  tph_pkg::entry_t  mov_q, mov_d;

  tph_pkg::status_e res_status_q, res_status_d;
  logic [tph_pkg::ID_W-1:0]   res_id_q, res_id_d;
  logic [tph_pkg::PRIO_W-1:0] res_prio_q, res_prio_d;

  logic             m_valid_q, m_valid_d;
  tph_pkg::status_e m_status_q, m_status_d;
  logic [tph_pkg::ID_W-1:0]   m_id_q, m_id_d;
  logic [tph_pkg::PRIO_W-1:0] m_prio_q, m_prio_d;

  // entry memory
  tph_pkg::entry_t entry_mem [tph_pkg::CAPACITY];
  tph_pkg::entry_t rd_a_q, rd_b_q;
  logic [AW-1:0]   rd_a_addr, rd_b_addr, wr_addr;
  logic            wr_en;
  tph_pkg::entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= entry_mem[rd_a_addr];
    rd_b_q <= entry_mem[rd_b_addr];
  end

  logic [tph_pkg::ID_W-1:0]   in_id;
  logic [tph_pkg::PRIO_W-1:0] in_prio;
  logic                       in_take;
  logic [CW-1:0]              cap_cnt;
  logic [IW-1:0]              l_idx, r_idx, cnt_ext;
  logic                       l_ok, r_ok, pick_l, pick_r;
  tph_pkg::entry_t            best_lr;

  assign in_id   = s_axis_tdata[15:0];
  assign in_prio = s_axis_tdata[18:16];
  assign in_take = s_axis_tvalid && s_axis_tready;
  assign cap_cnt = CW'(tph_pkg::CAPACITY);

  assign l_idx   = (IW'(pos_q) << 1) + IW'(1);
  assign r_idx   = l_idx + IW'(1);
  assign cnt_ext = IW'(count_q);
  assign l_ok    = l_idx < cnt_ext;
  assign r_ok    = r_idx < cnt_ext;
  assign pick_l  = l_ok && tph_pkg::beats(rd_a_q, mov_q);
  assign best_lr = pick_l ? rd_a_q : mov_q;
  assign pick_r  = r_ok && tph_pkg::beats(rd_b_q, best_lr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tph_pkg::S_IDLE;
      count_q   <= '0;
      seq_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      seq_q     <= seq_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    mov_q        <= mov_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_prio_q   <= res_prio_d;
    m_status_q   <= m_status_d;
    m_id_q       <= m_id_d;
    m_prio_q     <= m_prio_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    seq_d        = seq_q;
    pos_d        = pos_q;
    mov_d        = mov_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_prio_d   = res_prio_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_id_d       = m_id_q;
    m_prio_d     = m_prio_q;
    rd_a_addr    = '0;
    rd_b_addr    = '0;
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_data      = mov_q;
    s_axis_tready = (state_q == tph_pkg::S_IDLE);

    unique case (state_q)
      tph_pkg::S_IDLE: begin
        if (in_take) begin
          res_id_d   = '0;
          res_prio_d = '0;
          if (!s_axis_tuser) begin
            mov_d.id   = in_id;
            mov_d.prio = in_prio;
            mov_d.seq  = seq_q;
            if (count_q < cap_cnt) begin
              res_status_d = tph_pkg::ST_INSERTED;
              pos_d        = count_q[AW-1:0];
              count_d      = count_q + CW'(1);
              seq_d        = seq_q + 1'b1;
              state_d      = tph_pkg::S_UP_RD;
            end else begin
              rd_a_addr = AW'(tph_pkg::CAPACITY - 1);
              state_d   = tph_pkg::S_FULL_CHK;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = tph_pkg::ST_EMPTY;
              state_d      = tph_pkg::S_OUT;
            end else begin
              rd_a_addr = '0;
              rd_b_addr = AW'(count_q - CW'(1));
              count_d   = count_q - CW'(1);
              state_d   = tph_pkg::S_RM_LOAD;
            end
          end
        end
      end

      tph_pkg::S_FULL_CHK: begin
        if (rd_a_q.prio < mov_q.prio) begin
          res_status_d = tph_pkg::ST_EVICTED;
          res_id_d     = rd_a_q.id;
          res_prio_d   = rd_a_q.prio;
          pos_d        = AW'(tph_pkg::CAPACITY - 1);
          seq_d        = seq_q + 1'b1;
          state_d      = tph_pkg::S_UP_RD;
        end else begin
          res_status_d = tph_pkg::ST_FULL;
          state_d      = tph_pkg::S_OUT;
        end
      end

      tph_pkg::S_UP_RD: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = tph_pkg::S_OUT;
        end else begin
          rd_a_addr = (pos_q - AW'(1)) >> 1;
          state_d   = tph_pkg::S_UP_CMP;
        end
      end

      tph_pkg::S_UP_CMP: begin
        wr_en = 1'b1;
        if (tph_pkg::beats(mov_q, rd_a_q)) begin
          // parent drops into the hole, climb one level
          wr_data = rd_a_q;
          pos_d   = (pos_q - AW'(1)) >> 1;
          state_d = tph_pkg::S_UP_RD;
        end else begin
          state_d = tph_pkg::S_OUT;
        end
      end

      tph_pkg::S_RM_LOAD: begin
        res_status_d = tph_pkg::ST_REMOVED;
        res_id_d     = rd_a_q.id;
        res_prio_d   = rd_a_q.prio;
        mov_d        = rd_b_q;
        pos_d        = '0;
        state_d      = (count_q == '0) ? tph_pkg::S_OUT : tph_pkg::S_DN_RD;
      end

      tph_pkg::S_DN_RD: begin
        if (l_ok) begin
          rd_a_addr = l_idx[AW-1:0];
          rd_b_addr = r_idx[AW-1:0];
          state_d   = tph_pkg::S_DN_CMP;
        end else begin
          wr_en   = 1'b1;
          state_d = tph_pkg::S_OUT;
        end
      end

      tph_pkg::S_DN_CMP: begin
        wr_en = 1'b1;
        if (pick_r) begin
          wr_data = rd_b_q;
          pos_d   = r_idx[AW-1:0];
          state_d = tph_pkg::S_DN_RD;
        end else if (pick_l) begin
          wr_data = rd_a_q;
          pos_d   = l_idx[AW-1:0];
          state_d = tph_pkg::S_DN_RD;
        end else begin
          state_d = tph_pkg::S_OUT;
        end
      end

      tph_pkg::S_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_id_d     = res_id_q;
          m_prio_d   = res_prio_q;
          state_d    = tph_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tph_pkg::S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_prio_q, m_id_q};
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire
